// ===== src/dfd_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 update for the frame deframer.
// Depends on nothing; every other file of the block but dfd_if imports it.
package dfd_pkg;

   // Frame layout and counter limits.
   localparam int unsigned HDR_BYTES   = 9;
   localparam int unsigned MIN_FRAME   = 13;
   localparam int unsigned COUNT_W     = 17;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [15:0]        MAX_PAYLOAD_RESET = 16'd1023;

   // CRC-32, MSB first.
   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // End-of-frame status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
   localparam logic [1:0] STATUS_CRC_BAD   = 2'd2;
   localparam logic [1:0] STATUS_LEN_BAD   = 2'd3;

   // Header slot that a byte lands in.
   localparam logic [2:0] HDR_NONE   = 3'd0;
   localparam logic [2:0] HDR_RATE   = 3'd1;
   localparam logic [2:0] HDR_INTLV  = 3'd2;
   localparam logic [2:0] HDR_SEQ    = 3'd3;
   localparam logic [2:0] HDR_OFFSET = 3'd4;
   localparam logic [2:0] HDR_LENGTH = 3'd5;

   // One classified beat handed from the front end to the back end.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       crc_en;
      logic [2:0] hdr_sel;
      logic       emit;
      logic       too_short;
      logic       len_bad;
   } dfd_beat_type;

   // Feed one byte into the CRC register, one bit per step.
   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'd0};
      for (int k = 0; k < 8; k++) begin
         if (c[31]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== src/dfd_if.sv =====
// Valid/ready channel interfaces for the frame deframer's byte input and result output.
// Depends on nothing.
interface dfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface dfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [1:0]  status;
   logic        rate_format;
   logic [2:0]  rate_code;
   logic [7:0]  interleave_code;
   logic [7:0]  seq_number;
   logic [31:0] message_offset;
   logic [15:0] payload_length;

   modport source (
      output valid, output kind, output payload_byte, output status,
      output rate_format, output rate_code, output interleave_code,
      output seq_number, output message_offset, output payload_length,
      input ready
   );
   modport sink (
      input valid, input kind, input payload_byte, input status,
      input rate_format, input rate_code, input interleave_code,
      input seq_number, input message_offset, input payload_length,
      output ready
   );
endinterface

// ===== src/dfd_front.sv =====
// Front end: takes frame bytes, tracks position and length, classifies each beat.
// Depends on dfd_pkg and dfd_if.
module dfd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [15:0]           csr_write_data,
   dfd_req_if.sink               req,
   input  logic                  push_ready,
   output logic                  push_valid,
   output dfd_pkg::dfd_beat_type push_beat
);
   import dfd_pkg::*;

   logic [15:0]        max_payload_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        length_ff, length_in;
   logic [COUNT_W:0]   frame_len;
   logic [COUNT_W:0]   expect_len;
   logic               take;
   logic               in_payload;

   assign req.ready  = push_ready;
   assign take       = req.valid && push_ready;
   assign push_valid = req.valid;

   // The frame length the header announces, against the byte count so far.
   assign frame_len  = {1'b0, count_ff} + (COUNT_W+1)'(1);
   assign expect_len = (COUNT_W+1)'(MIN_FRAME) + (COUNT_W+1)'(length_in);

   // Length is captured big-endian from header bytes 7 and 8.
   always_comb begin
      length_in = length_ff;
      if (count_ff == COUNT_W'(7) || count_ff == COUNT_W'(8)) begin
         length_in = {length_ff[7:0], req.in_byte};
      end
   end

   assign in_payload = (count_ff >= COUNT_W'(HDR_BYTES)) &&
                       ({1'b0, count_ff} < (COUNT_W+1)'(HDR_BYTES) + (COUNT_W+1)'(length_in));

   // Classify the beat.
   always_comb begin
      push_beat.data      = req.in_byte;
      push_beat.last      = req.last_byte;
      push_beat.crc_en    = count_ff >= COUNT_W'(4);
      push_beat.emit      = !req.last_byte && in_payload && (length_in <= max_payload_ff);
      push_beat.too_short = frame_len < (COUNT_W+1)'(MIN_FRAME);
      push_beat.len_bad   = (length_in > max_payload_ff) || (expect_len != frame_len);
      if (count_ff == COUNT_W'(0)) begin
         push_beat.hdr_sel = HDR_RATE;
      end else if (count_ff == COUNT_W'(1)) begin
         push_beat.hdr_sel = HDR_INTLV;
      end else if (count_ff == COUNT_W'(2)) begin
         push_beat.hdr_sel = HDR_SEQ;
      end else if (count_ff >= COUNT_W'(3) && count_ff <= COUNT_W'(6)) begin
         push_beat.hdr_sel = HDR_OFFSET;
      end else if (count_ff == COUNT_W'(7) || count_ff == COUNT_W'(8)) begin
         push_beat.hdr_sel = HDR_LENGTH;
      end else begin
         push_beat.hdr_sel = HDR_NONE;
      end
   end

   // Saturating byte counter, cleared at the end of each frame.
   always_comb begin
      if (req.last_byte) begin
         count_in = '0;
      end else if (count_ff != COUNT_MAX) begin
         count_in = count_ff + COUNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
         count_ff       <= '0;
         length_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            max_payload_ff <= csr_write_data;
         end
         if (take) begin
            count_ff  <= count_in;
            length_ff <= req.last_byte ? 16'd0 : length_in;
         end
      end
   end

endmodule

// ===== src/dfd_queue.sv =====
// Two-entry queue of classified beats between the front end and the back end.
// Depends on dfd_pkg.
module dfd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  dfd_pkg::dfd_beat_type push_beat,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output dfd_pkg::dfd_beat_type pop_beat
);
   import dfd_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   dfd_beat_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               push, pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_beat   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_beat;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== src/dfd_back.sv =====
// Back end: header capture, CRC over delayed bytes, status decision and result register.
// Depends on dfd_pkg and dfd_if.
module dfd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  dfd_pkg::dfd_beat_type pop_beat,
   dfd_rsp_if.source             rsp
);
   import dfd_pkg::*;

   logic [31:0] crc_ff, crc_in;
   logic [7:0]  tail_ff [4];
   logic        rate_format_ff, rate_format_in;
   logic [2:0]  rate_code_ff, rate_code_in;
   logic [7:0]  interleave_ff, interleave_in;
   logic [7:0]  seq_ff, seq_in;
   logic [31:0] offset_ff, offset_in;
   logic [15:0] length_ff, length_in;
   logic [31:0] trailer;
   logic [1:0]  status_in;
   logic        pop;

   // Result register.
   logic        rsp_valid_ff;
   logic        kind_ff;
   logic [7:0]  payload_byte_ff;
   logic [1:0]  status_ff;
   logic        out_format_ff;
   logic [2:0]  out_code_ff;
   logic [7:0]  out_interleave_ff;
   logic [7:0]  out_seq_ff;
   logic [31:0] out_offset_ff;
   logic [15:0] out_length_ff;

   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign pop       = pop_valid && pop_ready;

   // Header fields after this beat.
   always_comb begin
      rate_format_in = rate_format_ff;
      rate_code_in   = rate_code_ff;
      interleave_in  = interleave_ff;
      seq_in         = seq_ff;
      offset_in      = offset_ff;
      length_in      = length_ff;
      case (pop_beat.hdr_sel)
         HDR_RATE: begin
            rate_format_in = pop_beat.data[7];
            rate_code_in   = pop_beat.data[6:4];
         end
         HDR_INTLV:  interleave_in = pop_beat.data;
         HDR_SEQ:    seq_in        = pop_beat.data;
         HDR_OFFSET: offset_in     = {offset_ff[23:0], pop_beat.data};
         HDR_LENGTH: length_in     = {length_ff[7:0], pop_beat.data};
         default: begin
         end
      endcase
   end

   // The oldest held byte enters the CRC; the newest four form the trailer.
   assign crc_in  = pop_beat.crc_en ? crc_feed(crc_ff, tail_ff[0]) : crc_ff;
   assign trailer = {tail_ff[1], tail_ff[2], tail_ff[3], pop_beat.data};

   // First failing check wins.
   always_comb begin
      if (pop_beat.too_short) begin
         status_in = STATUS_TOO_SHORT;
      end else if (~crc_in != trailer) begin
         status_in = STATUS_CRC_BAD;
      end else if (pop_beat.len_bad) begin
         status_in = STATUS_LEN_BAD;
      end else begin
         status_in = STATUS_OK;
      end
   end

   // Frame state, cleared after the final byte.
   always_ff @(posedge clock) begin
      if (reset || (pop && pop_beat.last)) begin
         crc_ff         <= CRC_INIT;
         tail_ff        <= '{default: 8'd0};
         rate_format_ff <= 1'b0;
         rate_code_ff   <= '0;
         interleave_ff  <= '0;
         seq_ff         <= '0;
         offset_ff      <= '0;
         length_ff      <= '0;
      end else if (pop) begin
         crc_ff         <= crc_in;
         tail_ff[0]     <= tail_ff[1];
         tail_ff[1]     <= tail_ff[2];
         tail_ff[2]     <= tail_ff[3];
         tail_ff[3]     <= pop_beat.data;
         rate_format_ff <= rate_format_in;
         rate_code_ff   <= rate_code_in;
         interleave_ff  <= interleave_in;
         seq_ff         <= seq_in;
         offset_ff      <= offset_in;
         length_ff      <= length_in;
      end
   end

   // Result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         rsp_valid_ff <= pop && (pop_beat.last || pop_beat.emit);
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (pop && pop_beat.last) begin
         kind_ff           <= KIND_STATUS;
         payload_byte_ff   <= '0;
         status_ff         <= status_in;
         out_format_ff     <= rate_format_in;
         out_code_ff       <= rate_code_in;
         out_interleave_ff <= interleave_in;
         out_seq_ff        <= seq_in;
         out_offset_ff     <= offset_in;
         out_length_ff     <= length_in;
      end else if (pop && pop_beat.emit) begin
         kind_ff           <= KIND_PAYLOAD;
         payload_byte_ff   <= pop_beat.data;
         status_ff         <= STATUS_OK;
         out_format_ff     <= 1'b0;
         out_code_ff       <= '0;
         out_interleave_ff <= '0;
         out_seq_ff        <= '0;
         out_offset_ff     <= '0;
         out_length_ff     <= '0;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.kind            = kind_ff;
   assign rsp.payload_byte    = payload_byte_ff;
   assign rsp.status          = status_ff;
   assign rsp.rate_format     = out_format_ff;
   assign rsp.rate_code       = out_code_ff;
   assign rsp.interleave_code = out_interleave_ff;
   assign rsp.seq_number      = out_seq_ff;
   assign rsp.message_offset  = out_offset_ff;
   assign rsp.payload_length  = out_length_ff;

endmodule

// ===== src/data_frame_deframer_crc32.sv =====
// Top level of the CRC-32 checked data frame deframer.
// Depends on dfd_pkg, dfd_if, dfd_front, dfd_queue and dfd_back.
//
//   Channel | Direction | Beat contents
//   --------+-----------+-----------------------------------------------------
//   req     | in        | in_byte, last_byte
//   rsp     | out       | kind, payload_byte, status, captured header fields
//   csr     | in        | max_payload write (enable + 16-bit data)
//
// One byte is accepted per cycle while rsp is not stalled. Each byte passes
// from the front end into the two-entry queue, and the back end registers its
// result; the back end updates the CRC a whole byte at a time.
// Reset is synchronous; max_payload returns to 1023 and the frame state clears.
// A stalled rsp fills the queue, after which req.ready drops until it drains.
module data_frame_deframer_crc32 (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   dfd_req_if.sink     req,
   dfd_rsp_if.source   rsp
);
   import dfd_pkg::*;

   dfd_beat_type push_beat, pop_beat;
   logic         push_valid, push_ready;
   logic         pop_valid, pop_ready;

   dfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .push_ready       (push_ready),
      .push_valid       (push_valid),
      .push_beat        (push_beat)
   );

   dfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_beat  (push_beat),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_beat   (pop_beat)
   );

   dfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_beat  (pop_beat),
      .rsp       (rsp)
   );

endmodule
